@@ sv/cdef_pkg.sv @@
// Shared types and constants for the cylindrical density edge finder.
// No dependencies; every other file imports this package.
package cdef_pkg;

  localparam int R_BINS = 32;
  localparam int Z_BINS = 32;
  localparam int RW = $clog2(R_BINS);
  localparam int ZW = $clog2(Z_BINS);
  localparam int AW = $clog2(R_BINS * Z_BINS);
  localparam int DEPTH = R_BINS * Z_BINS;
  localparam int SUM_W = 40;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_Z_OFFSET = 3'd2;
  localparam logic [2:0] REG_INV_DR = 3'd3;
  localparam logic [2:0] REG_INV_DZ = 3'd4;
  localparam logic [2:0] REG_DENS_SCALE = 3'd5;
  localparam logic [2:0] REG_THRESH = 3'd6;
  localparam logic [2:0] REG_MIN_Z_BIN = 3'd7;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_RBIN,
    ST_RD,
    ST_WR,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_CMP,
    ST_SC_UPD
  } state_t;

  // Phase strobes from the sequencer to the edge tracker.
  typedef struct packed {
    logic clear;
    logic mul;
    logic cmp;
    logic upd;
  } edge_ctl_t;

endpackage

@@ sv/cylindrical_density_edge_finder_core.sv @@
// Top level: histogram memory, particle binning sequencer and scan control.
// Depends on cdef_pkg, cdef_sqrt and cdef_edge.
//
// A particle item finds its radius in the 33-step square root unit; the
// block then reads, adds and writes back one 40-bit histogram entry. A
// finish item walks all 1024 entries, each through read, multiply,
// compare and update, clearing each entry as it reads it, and strobes
// one result per height column on result_valid; the receiver cannot
// stall, so each result is present for one cycle only. After reset,
// busy stays high while the memory is swept to zero. Configuration
// writes are taken at any time.
module cylindrical_density_edge_finder_core import cdef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] mass,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [5:0]  r_bin,
  output logic [5:0]  z_bin,
  output logic        found,
  output logic        last
);

  state_t state, state_next;

  logic [31:0] center_x, center_y, z_offset, inv_dr, inv_dz;
  logic [31:0] dens_scale, thresh_dens;
  logic [6:0]  min_z_bin;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] mem_q;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [SUM_W-1:0] mem_wdata;

  logic [32:0]  ax, ay, zs;
  logic [31:0]  mass_q;
  logic [65:0]  qx, qy;
  logic [31:0]  zb_raw;
  logic         z_neg;
  logic         sqrt_start, sqrt_done;
  logic [32:0]  root;
  logic [32:0]  rb_raw;
  logic [AW-1:0] addr;
  logic [AW:0]  clr_cnt;
  logic [RW-1:0] row;
  logic [ZW-1:0] col;
  logic         accept;
  logic         drop;
  logic [ZW-1:0] zb;
  logic [SUM_W:0] sum_add;
  logic         seen_now;
  logic [RW-1:0] loc_now;
  edge_ctl_t    ectl;
  logic signed [32:0] dx, dy;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      z_offset <= '0;
      inv_dr <= 32'd65536;
      inv_dz <= 32'd65536;
      dens_scale <= 32'd65536;
      thresh_dens <= '0;
      min_z_bin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:   center_x <= cfg_data;
        REG_CENTER_Y:   center_y <= cfg_data;
        REG_Z_OFFSET:   z_offset <= cfg_data;
        REG_INV_DR:     inv_dr <= cfg_data;
        REG_INV_DZ:     inv_dz <= cfg_data;
        REG_DENS_SCALE: dens_scale <= cfg_data;
        REG_THRESH:     thresh_dens <= cfg_data;
        REG_MIN_Z_BIN:  min_z_bin <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  assign dx = $signed({pos_x[31], pos_x}) - $signed({center_x[31], center_x});
  assign dy = $signed({pos_y[31], pos_y}) - $signed({center_y[31], center_y});

  // Height bin: a negative offset height drops the particle unless the
  // bin width reciprocal is zero, which folds everything into bin 0.
  always_comb begin
    drop = 1'b0;
    zb = zb_raw[ZW-1:0];
    if (z_neg) begin
      zb = '0;
      drop = inv_dz != 32'd0;
    end else if (zb_raw >= 32'(Z_BINS)) begin
      drop = 1'b1;
    end
    if (rb_raw >= 33'(R_BINS)) begin
      drop = 1'b1;
    end
  end

  assign sum_add = {1'b0, mem_q} + {9'd0, mass_q};

  cdef_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(sqrt_start),
    .radicand(qx + qy),
    .done(sqrt_done),
    .root(root)
  );

  cdef_edge u_edge (
    .clk(clk),
    .rst(rst),
    .ctl(ectl),
    .sum(mem_q),
    .row(row),
    .dens_scale(dens_scale),
    .thresh(thresh_dens),
    .seen_now(seen_now),
    .loc_now(loc_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sqrt_start = 1'b0;
    mem_we = 1'b0;
    mem_addr = AW'(AW'(row) * AW'(Z_BINS)) + AW'(col);
    mem_wdata = '0;
    ectl = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt[AW-1:0];
        if (clr_cnt == (AW+1)'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ectl.clear = req_type;
          state_next = req_type ? ST_SC_RD : ST_SQX;
        end
      end
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_SUM;
      ST_SUM: begin
        sqrt_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_RBIN;
        end
      end
      ST_RBIN: state_next = ST_RD;
      ST_RD: begin
        mem_addr = AW'(AW'(rb_raw[RW-1:0]) * AW'(Z_BINS)) + AW'(zb);
        state_next = drop ? ST_IDLE : ST_WR;
      end
      ST_WR: begin
        mem_we = 1'b1;
        mem_addr = addr;
        mem_wdata = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        state_next = ST_IDLE;
      end
      ST_SC_RD: begin
        // The entry is read and cleared in the same cycle.
        mem_we = 1'b1;
        state_next = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        ectl.mul = 1'b1;
        state_next = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        ectl.cmp = 1'b1;
        state_next = ST_SC_UPD;
      end
      ST_SC_UPD: begin
        ectl.upd = 1'b1;
        if (row == RW'(R_BINS - 1) && col == ZW'(Z_BINS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SC_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      row <= '0;
      col <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        row <= '0;
        col <= '0;
      end
      if (state == ST_SC_UPD) begin
        if (row == RW'(R_BINS - 1)) begin
          row <= '0;
          col <= col + 1'b1;
          result_valid <= 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax <= dx[32] ? 33'(-dx) : 33'(dx);
      ay <= dy[32] ? 33'(-dy) : 33'(dy);
      zs <= 33'($signed({pos_z[31], pos_z}) + $signed({z_offset[31], z_offset}));
      mass_q <= mass;
    end
    if (state == ST_SQX) begin
      qx <= ax * ax;
    end
    if (state == ST_SQY) begin
      qy <= ay * ay;
    end
    if (state == ST_SUM) begin
      z_neg <= zs[32];
      zb_raw <= 32'(({32'd0, zs[31:0]} * {32'd0, inv_dz}) >> 32);
    end
    if (state == ST_RBIN) begin
      rb_raw <= 33'(({32'd0, root} * {33'd0, inv_dr}) >> 32);
    end
    if (state == ST_RD) begin
      addr <= mem_addr;
    end
    if (state == ST_SC_UPD && row == RW'(R_BINS - 1)) begin
      found <= seen_now && ({1'b0, 6'(col)} >= min_z_bin);
      r_bin <= (seen_now && ({1'b0, 6'(col)} >= min_z_bin)) ? 6'(loc_now) : 6'd0;
      z_bin <= 6'(col);
      last <= col == ZW'(Z_BINS - 1);
    end
  end

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_SC_UPD)
    else $error("result strobe without a column update");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after an accepted item");

  a_last_column: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> z_bin == 6'(Z_BINS - 1))
    else $error("last flag on the wrong column");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != ST_IDLE)
    else $error("histogram written while idle");

endmodule

@@ sv/cdef_sqrt.sv @@
// Iterative floor square root of a 66-bit radicand, two bits per cycle.
// Depends on cdef_pkg.
module cdef_sqrt import cdef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [65:0] radicand,
  output logic        done,
  output logic [32:0] root
);

  logic [65:0] val;
  logic [35:0] rem;
  logic [32:0] res;
  logic [5:0]  steps;
  logic        running;
  logic [35:0] rem_shift;
  logic [35:0] trial;

  assign rem_shift = {rem[33:0], val[65:64]};
  assign trial = {1'b0, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps <= 6'd0;
      end else if (running) begin
        steps <= steps + 6'd1;
        if (steps == 6'd32) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      rem <= '0;
      res <= '0;
    end else if (running) begin
      val <= {val[63:0], 2'b00};
      if (rem_shift >= trial) begin
        rem <= rem_shift - trial;
        res <= {res[31:0], 1'b1};
      end else begin
        rem <= rem_shift;
        res <= {res[31:0], 1'b0};
      end
    end
  end

  assign root = res;

endmodule

@@ sv/cdef_edge.sv @@
// Density compare and edge tracking for one radial walk of the scan.
// Depends on cdef_pkg. Density is compared against the threshold by
// cross-multiplying with the ring divisor 2i+1 instead of dividing.
module cdef_edge import cdef_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  edge_ctl_t         ctl,
  input  logic [SUM_W-1:0]  sum,
  input  logic [RW-1:0]     row,
  input  logic [31:0]       dens_scale,
  input  logic [31:0]       thresh,
  output logic              seen_now,
  output logic [RW-1:0]     loc_now
);

  logic [39:0]   prod_hi;
  logic [63:0]   prod_lo;
  logic [38:0]   thr_div;
  logic [RW:0]   div;
  logic [RW:0]   div_q;
  logic [56:0]   q;
  logic          ge;
  logic          le;
  logic          armed;
  logic          seen;
  logic [RW-1:0] loc;
  logic          armed_now;

  assign div = {row, 1'b1};
  assign q = {1'b0, prod_hi, 16'd0} + {9'd0, prod_lo[63:16]};

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_hi <= {32'd0, sum[39:32]} * {8'd0, dens_scale};
      prod_lo <= {32'd0, sum[31:0]} * {32'd0, dens_scale};
      thr_div <= 39'(thresh * div);
      div_q <= div;
    end
    if (ctl.cmp) begin
      // floor(q/D) >= T exactly when q >= T*D; the saturated value is
      // at most T exactly when q < T*D + D or T is the top code.
      ge <= q >= {18'd0, thr_div};
      le <= (thresh == 32'hFFFF_FFFF) ||
            (q < ({18'd0, thr_div} + 57'(div_q)));
    end
  end

  always_comb begin
    armed_now = armed || ge;
    seen_now = seen;
    loc_now = loc;
    if (armed_now && le) begin
      armed_now = 1'b0;
      seen_now = 1'b1;
      loc_now = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      armed <= 1'b0;
      seen <= 1'b0;
      loc <= '0;
    end else if (ctl.upd) begin
      if (row == RW'(R_BINS - 1)) begin
        armed <= 1'b0;
        seen <= 1'b0;
        loc <= '0;
      end else begin
        armed <= armed_now;
        seen <= seen_now;
        loc <= loc_now;
      end
    end
  end

endmodule
